// ===== sv/intel_hex_record_loader_macros.svh =====
// assertion macros for the hex record loader
`ifndef INTEL_HEX_RECORD_LOADER_MACROS_SVH
`define INTEL_HEX_RECORD_LOADER_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent on the same edge
`define HEXL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hexl check failed");
// condition holds on every edge out of reset
`define HEXL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hexl check failed");
`else
`define HEXL_ASSERT_IMPL(label, ante, cons)
`define HEXL_ASSERT_ALWAYS(label, cond)
`endif

`endif

// ===== sv/hexl_pkg.sv =====
// shared types and constants for the hex record loader
`default_nettype none

package hexl_pkg;

    localparam int IMAGE_DEPTH  = 4096;
    localparam int IMG_AW       = 12;
    localparam int RECORD_DEPTH = 256;
    localparam int REC_AW       = 8;
    localparam int CQ_DEPTH     = 4;
    localparam int CQ_AW        = 2;

    localparam logic [12:0] IMAGE_LIMIT = 13'(IMAGE_DEPTH);
    localparam logic [12:0] SIZE_RESET  = 13'd4096;
    localparam logic [7:0]  FILL_RESET  = 8'hFF;

    // request codes
    localparam logic [1:0] REQ_CHAR  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_SIZE = 2'd1;
    localparam logic [1:0] CFG_FILL = 2'd2;

    // record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ESA  = 8'h02;
    localparam logic [7:0] REC_SSA  = 8'h03;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] REC_SLA  = 8'h05;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FORMAT      = 3'd1,
        ST_CHECKSUM    = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        RK_STATUS = 2'd0,
        RK_READ   = 2'd1,
        RK_CLEAR  = 2'd2
    } reply_kind_t;

    typedef enum logic [2:0] {
        CMD_BYTE,
        CMD_FORMAT,
        CMD_FINISH,
        CMD_READ,
        CMD_CLEAR
    } cmd_op_t;

    // one command from the parser to the executor
    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  data;
        logic [11:0] index;
        logic [7:0]  length;
        logic [15:0] address;
        logic [7:0]  kind;
        logic        sum_ok;
        logic [15:0] ext_value;
    } cmd_t;

    // one result beat
    typedef struct packed {
        reply_kind_t kind;
        status_t     status;
        logic [7:0]  read_data;
        logic        eof_hit;
        logic        any_data;
        logic [12:0] low_mark;
        logic [12:0] high_mark;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/hexl_parse.sv =====
// front end: character parser that turns requests into executor commands
`default_nettype none

module hexl_parse (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [1:0]     req_type,
    input  wire logic [7:0]     char_code,
    input  wire logic [11:0]    read_index,
    output hexl_pkg::cmd_t      cmd,
    output logic                cmd_valid
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DISCARD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [9:0]  dc_reg, dc_next;
    logic [3:0]  hn_reg, hn_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  b0_reg, b0_next;
    logic [7:0]  b1_reg, b1_next;

    logic        is_hex;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [8:0]  idx;
    logic [7:0]  sum_new;
    logic        is_ws;

    // hex digit decode, either case
    always_comb
    begin
        is_hex = 1'b1;
        nib    = 4'd0;
        if (char_code inside {[8'h30:8'h39]})
            nib = 4'(char_code - 8'h30);
        else if (char_code inside {[8'h61:8'h66]})
            nib = 4'(char_code - 8'h57);
        else if (char_code inside {[8'h41:8'h46]})
            nib = 4'(char_code - 8'h37);
        else
            is_hex = 1'b0;
    end

    assign is_ws    = (char_code == 8'h20) || (char_code == 8'h09) ||
                      (char_code == 8'h0D) || (char_code == 8'h0A);
    assign byte_val = {hn_reg, nib};
    assign idx      = dc_reg[9:1];
    assign sum_new  = sum_reg + byte_val;

    // next state and command
    always_comb
    begin
        phase_next = phase_reg;
        dc_next    = dc_reg;
        hn_next    = hn_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        kind_next  = kind_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        cmd_valid  = 1'b0;
        cmd        = '0;
        cmd.op     = hexl_pkg::CMD_BYTE;
        if (accept)
        begin
            case (req_type)
                hexl_pkg::REQ_CHAR:
                begin
                    case (phase_reg)
                        PH_DISCARD:
                        begin
                            if (char_code == 8'h0A)
                                phase_next = PH_SKIP;
                        end
                        PH_DIGITS:
                        begin
                            if (!is_hex)
                            begin
                                phase_next = (char_code == 8'h0A) ? PH_SKIP : PH_DISCARD;
                                cmd_valid  = 1'b1;
                                cmd.op     = hexl_pkg::CMD_FORMAT;
                            end
                            else if (!dc_reg[0])
                            begin
                                hn_next = nib;
                                dc_next = dc_reg + 10'd1;
                            end
                            else
                            begin
                                dc_next  = dc_reg + 10'd1;
                                sum_next = sum_new;
                                if (idx == 9'd0)
                                    len_next = byte_val;
                                else if (idx == 9'd1)
                                    addr_next = {byte_val, addr_reg[7:0]};
                                else if (idx == 9'd2)
                                    addr_next = {addr_reg[15:8], byte_val};
                                else if (idx == 9'd3)
                                    kind_next = byte_val;
                                else if ({1'b0, idx} < (10'd4 + {2'b00, len_reg}))
                                begin
                                    cmd_valid = 1'b1;
                                    cmd.op    = hexl_pkg::CMD_BYTE;
                                    cmd.data  = byte_val;
                                    cmd.index = {4'd0, 8'(idx - 9'd4)};
                                    if (idx == 9'd4)
                                        b0_next = byte_val;
                                    if (idx == 9'd5)
                                        b1_next = byte_val;
                                end
                                else
                                begin
                                    // checksum byte closes the record
                                    phase_next    = PH_DISCARD;
                                    cmd_valid     = 1'b1;
                                    cmd.op        = hexl_pkg::CMD_FINISH;
                                    cmd.length    = len_reg;
                                    cmd.address   = addr_reg;
                                    cmd.kind      = kind_reg;
                                    cmd.sum_ok    = (sum_new == 8'd0);
                                    cmd.ext_value = {b0_reg, b1_reg};
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_SKIP;
                            if (is_ws)
                                phase_next = PH_SKIP;
                            else if (char_code == 8'h3A)
                            begin
                                phase_next = PH_DIGITS;
                                dc_next    = 10'd0;
                                sum_next   = 8'd0;
                            end
                            else
                            begin
                                phase_next = PH_DISCARD;
                                cmd_valid  = 1'b1;
                                cmd.op     = hexl_pkg::CMD_FORMAT;
                            end
                        end
                    endcase
                end
                hexl_pkg::REQ_READ:
                begin
                    cmd_valid = 1'b1;
                    cmd.op    = hexl_pkg::CMD_READ;
                    cmd.index = read_index;
                end
                hexl_pkg::REQ_CLEAR:
                begin
                    cmd_valid = 1'b1;
                    cmd.op    = hexl_pkg::CMD_CLEAR;
                end
                default:
                begin
                    cmd_valid = 1'b0;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            dc_reg    <= 10'd0;
            hn_reg    <= 4'd0;
            sum_reg   <= 8'd0;
            len_reg   <= 8'd0;
            addr_reg  <= 16'd0;
            kind_reg  <= 8'd0;
            b0_reg    <= 8'd0;
            b1_reg    <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            dc_reg    <= dc_next;
            hn_reg    <= hn_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
            kind_reg  <= kind_next;
            b0_reg    <= b0_next;
            b1_reg    <= b1_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hexl_cmdq.sv =====
// short command queue between parser and executor
`default_nettype none

module hexl_cmdq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire hexl_pkg::cmd_t cmd_in,
    output logic                full,
    output logic                valid,
    output hexl_pkg::cmd_t      cmd_out,
    input  wire logic           pop
);

    hexl_pkg::cmd_t                 slot_reg [hexl_pkg::CQ_DEPTH];
    logic [hexl_pkg::CQ_AW-1:0]     wp_reg, rp_reg;
    logic [hexl_pkg::CQ_AW:0]       cnt_reg;
    logic                           do_push, do_pop;

    assign full    = (cnt_reg == (hexl_pkg::CQ_AW+1)'(hexl_pkg::CQ_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign cmd_out = slot_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wp_reg] <= cmd_in;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= rp_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hexl_exec.sv =====
// back end: record commit, image memory, clear sweep and result register
`default_nettype none

module hexl_exec (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    input  wire logic           q_valid,
    input  wire hexl_pkg::cmd_t q_cmd,
    output logic                q_pop,
    output logic                init_busy,
    output logic                res_valid,
    output hexl_pkg::res_t      res,
    input  wire logic           res_pop
);

    `include "intel_hex_record_loader_macros.svh"

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_ADDR,
        S_SUB,
        S_RANGE,
        S_COPY,
        S_REPLY
    } state_t;

    state_t                     state_reg;
    hexl_pkg::cmd_t             cmd_reg;
    logic [hexl_pkg::IMG_AW-1:0] sweep_reg;
    logic [31:0]                base_reg;
    logic [12:0]                size_reg;
    logic [7:0]                 fill_reg;
    logic [31:0]                ext_reg;
    logic [12:0]                low_reg, high_reg;
    logic                       any_reg, eof_reg;
    logic [31:0]                abs_reg;
    logic [32:0]                diff_reg;
    logic [12:0]                off_reg;
    logic [8:0]                 cnt_reg;
    logic                       wv_reg;
    logic [hexl_pkg::IMG_AW-1:0] wa_reg;
    hexl_pkg::status_t          st_reg;
    hexl_pkg::reply_kind_t      rk_reg;
    logic [7:0]                 rd_reg;
    logic                       res_valid_reg;
    hexl_pkg::res_t             res_reg;

    logic [7:0]                 rbuf [hexl_pkg::RECORD_DEPTH];
    logic [7:0]                 img  [hexl_pkg::IMAGE_DEPTH];
    logic [7:0]                 rbuf_q, img_q;

    logic                       rbuf_we;
    logic                       img_we;
    logic [hexl_pkg::IMG_AW-1:0] img_waddr;
    logic [7:0]                 img_wdata;
    logic                       sweeping;
    logic                       sweep_last;
    logic                       res_load;
    logic [12:0]                limit;
    logic [33:0]                span_end;
    logic [12:0]                rec_end;
    logic                       copy_more;

    assign sweeping   = (state_reg == S_INIT) || (state_reg == S_CLEAR);
    assign sweep_last = (sweep_reg == hexl_pkg::IMG_AW'(hexl_pkg::IMAGE_DEPTH - 1));
    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign init_busy  = (state_reg == S_INIT);
    assign rbuf_we    = q_pop && (q_cmd.op == hexl_pkg::CMD_BYTE);
    assign img_we     = wv_reg || sweeping;
    assign img_waddr  = wv_reg ? wa_reg : sweep_reg;
    assign img_wdata  = wv_reg ? rbuf_q :
                        ((state_reg == S_INIT) ? hexl_pkg::FILL_RESET : fill_reg);
    assign res_load   = (state_reg == S_REPLY) && (!res_valid_reg || res_pop);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    assign limit      = (size_reg > hexl_pkg::IMAGE_LIMIT) ? hexl_pkg::IMAGE_LIMIT : size_reg;
    assign span_end   = {1'b0, diff_reg} + {26'd0, cmd_reg.length};
    assign rec_end    = off_reg + {5'd0, cmd_reg.length};
    assign copy_more  = (cnt_reg < {1'b0, cmd_reg.length});

    // record buffer
    always_ff @(posedge clk)
    begin
        if (rbuf_we)
            rbuf[q_cmd.index[hexl_pkg::REC_AW-1:0]] <= q_cmd.data;
        rbuf_q <= rbuf[cnt_reg[hexl_pkg::REC_AW-1:0]];
    end

    // image memory
    always_ff @(posedge clk)
    begin
        if (img_we)
            img[img_waddr] <= img_wdata;
        img_q <= img[q_cmd.index];
    end

    // copy write stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wv_reg <= 1'b0;
        else
            wv_reg <= (state_reg == S_COPY) && copy_more;
    end

    always_ff @(posedge clk)
    begin
        wa_reg <= hexl_pkg::IMG_AW'(off_reg + {4'd0, cnt_reg});
    end

    // sequencer, configuration, flags and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cmd_reg       <= '0;
            sweep_reg     <= '0;
            base_reg      <= 32'd0;
            size_reg      <= hexl_pkg::SIZE_RESET;
            fill_reg      <= hexl_pkg::FILL_RESET;
            ext_reg       <= 32'd0;
            low_reg       <= 13'd0;
            high_reg      <= 13'd0;
            any_reg       <= 1'b0;
            eof_reg       <= 1'b0;
            abs_reg       <= 32'd0;
            diff_reg      <= 33'd0;
            off_reg       <= 13'd0;
            cnt_reg       <= 9'd0;
            st_reg        <= hexl_pkg::ST_OK;
            rk_reg        <= hexl_pkg::RK_STATUS;
            rd_reg        <= 8'd0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    hexl_pkg::CFG_BASE: base_reg <= cfg_data;
                    hexl_pkg::CFG_SIZE: size_reg <= cfg_data[12:0];
                    hexl_pkg::CFG_FILL: fill_reg <= cfg_data[7:0];
                    default:            base_reg <= base_reg;
                endcase
            end

            // result beat leaves
            if (res_pop && res_valid_reg)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_last)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_cmd;
                        rk_reg  <= hexl_pkg::RK_STATUS;
                        st_reg  <= hexl_pkg::ST_OK;
                        rd_reg  <= 8'd0;
                        case (q_cmd.op)
                            hexl_pkg::CMD_BYTE:
                            begin
                                state_reg <= S_IDLE;
                            end
                            hexl_pkg::CMD_FORMAT:
                            begin
                                st_reg    <= hexl_pkg::ST_FORMAT;
                                state_reg <= S_REPLY;
                            end
                            hexl_pkg::CMD_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            hexl_pkg::CMD_CLEAR:
                            begin
                                ext_reg   <= 32'd0;
                                low_reg   <= 13'd0;
                                high_reg  <= 13'd0;
                                any_reg   <= 1'b0;
                                eof_reg   <= 1'b0;
                                sweep_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                            hexl_pkg::CMD_FINISH:
                            begin
                                state_reg <= S_REPLY;
                                if (!q_cmd.sum_ok)
                                    st_reg <= hexl_pkg::ST_CHECKSUM;
                                else
                                begin
                                    case (q_cmd.kind)
                                        hexl_pkg::REC_DATA:
                                            state_reg <= S_ADDR;
                                        hexl_pkg::REC_EOF:
                                            eof_reg <= 1'b1;
                                        hexl_pkg::REC_ESA, hexl_pkg::REC_ELA:
                                        begin
                                            if (q_cmd.length != 8'd2)
                                                st_reg <= hexl_pkg::ST_FORMAT;
                                            else if (q_cmd.kind == hexl_pkg::REC_ELA)
                                                ext_reg <= {q_cmd.ext_value, 16'd0};
                                            else
                                                ext_reg <= {12'd0, q_cmd.ext_value, 4'd0};
                                        end
                                        hexl_pkg::REC_SSA, hexl_pkg::REC_SLA:
                                            st_reg <= hexl_pkg::ST_OK;
                                        default:
                                            st_reg <= hexl_pkg::ST_UNSUPPORTED;
                                    endcase
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    rk_reg    <= hexl_pkg::RK_READ;
                    rd_reg    <= img_q;
                    state_reg <= S_REPLY;
                end
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_last)
                    begin
                        rk_reg    <= hexl_pkg::RK_CLEAR;
                        state_reg <= S_REPLY;
                    end
                end
                S_ADDR:
                begin
                    abs_reg   <= ext_reg + {16'd0, cmd_reg.address};
                    state_reg <= S_SUB;
                end
                S_SUB:
                begin
                    diff_reg  <= {1'b0, abs_reg} - {1'b0, base_reg};
                    state_reg <= S_RANGE;
                end
                S_RANGE:
                begin
                    // borrow means below the base
                    if (diff_reg[32] || (span_end > {21'd0, limit}))
                    begin
                        st_reg    <= hexl_pkg::ST_OVERFLOW;
                        state_reg <= S_REPLY;
                    end
                    else
                    begin
                        off_reg   <= diff_reg[12:0];
                        cnt_reg   <= 9'd0;
                        state_reg <= S_COPY;
                    end
                end
                S_COPY:
                begin
                    if (copy_more)
                        cnt_reg <= cnt_reg + 9'd1;
                    else
                    begin
                        if (!any_reg)
                        begin
                            low_reg  <= off_reg;
                            high_reg <= rec_end;
                            any_reg  <= 1'b1;
                        end
                        else
                        begin
                            if (off_reg < low_reg)
                                low_reg <= off_reg;
                            if (rec_end > high_reg)
                                high_reg <= rec_end;
                        end
                        state_reg <= S_REPLY;
                    end
                end
                S_REPLY:
                begin
                    if (res_load)
                    begin
                        res_reg.kind      <= rk_reg;
                        res_reg.status    <= st_reg;
                        res_reg.read_data <= rd_reg;
                        res_reg.eof_hit   <= eof_reg;
                        res_reg.any_data  <= any_reg;
                        res_reg.low_mark  <= low_reg;
                        res_reg.high_mark <= high_reg;
                        res_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `HEXL_ASSERT_IMPL(a_copy_write_in_copy, wv_reg, state_reg == S_COPY)
    `HEXL_ASSERT_IMPL(a_marks_ordered, any_reg, low_reg <= high_reg)
    `HEXL_ASSERT_IMPL(a_marks_idle_zero, !any_reg, (low_reg == 13'd0) && (high_reg == 13'd0))
    `HEXL_ASSERT_ALWAYS(a_high_in_image, high_reg <= hexl_pkg::IMAGE_LIMIT)

endmodule

`default_nettype wire

// ===== sv/intel_hex_record_loader.sv =====
// top level of the hex record loader
//
//  channel   direction  handshake           payload
//  request   in         push / full         req_type, char_code, read_index
//  result    out        pop / empty         reply_kind, status, read_data, flags, marks
//  config    in         cfg_we (no wait)    cfg_index, cfg_data
//
// a character, read or clear request is taken when the command queue has room.
// a data record commit pops the command, forms the absolute address, subtracts the base and
// range-checks, then copies length bytes through the record buffer port and replies; a read
// pops, reads the image and replies, and a clear sweeps every image byte. after reset a clearing
// pass over all 4096 image bytes fills the image; full stays high meanwhile. a waiting result
// stalls the executor; the parser keeps filling the four-entry queue until it is full.
`default_nettype none

module intel_hex_record_loader (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [1:0]     req_type,
    input  wire logic [7:0]     char_code,
    input  wire logic [11:0]    read_index,
    output logic                empty,
    input  wire logic           pop,
    output logic [1:0]          reply_kind,
    output logic [2:0]          status,
    output logic [7:0]          read_data,
    output logic                eof_hit,
    output logic                any_data,
    output logic [12:0]         low_mark,
    output logic [12:0]         high_mark,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data
);

    hexl_pkg::cmd_t     p_cmd;
    logic               p_valid;
    hexl_pkg::cmd_t     q_cmd;
    logic               q_valid;
    logic               q_full;
    logic               q_pop;
    logic               init_busy;
    logic               res_valid;
    hexl_pkg::res_t     res;
    logic               accept;

    assign full   = q_full || init_busy;
    assign accept = push && !full;

    // front: parser
    hexl_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .char_code  (char_code),
        .read_index (read_index),
        .cmd        (p_cmd),
        .cmd_valid  (p_valid)
    );

    // command queue
    hexl_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (p_valid),
        .cmd_in  (p_cmd),
        .full    (q_full),
        .valid   (q_valid),
        .cmd_out (q_cmd),
        .pop     (q_pop)
    );

    // back: executor
    hexl_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    // result beat
    assign empty      = !res_valid;
    assign reply_kind = res.kind;
    assign status     = res.status;
    assign read_data  = res.read_data;
    assign eof_hit    = res.eof_hit;
    assign any_data   = res.any_data;
    assign low_mark   = res.low_mark;
    assign high_mark  = res.high_mark;

endmodule

`default_nettype wire

// ===== bench/intel_hex_record_loader_checker.sv =====
// checker for the hex record loader: predicts every reply and compares beats
`default_nettype none

module intel_hex_record_loader_checker
    import hexl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  char_code,
    input  wire logic [11:0] read_index,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [1:0]  reply_kind,
    input  wire logic [2:0]  status,
    input  wire logic [7:0]  read_data,
    input  wire logic        eof_hit,
    input  wire logic        any_data,
    input  wire logic [12:0] low_mark,
    input  wire logic [12:0] high_mark,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               replies_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {LN_SKIP, LN_DIGITS, LN_DISCARD} line_t;

    // predictor state
    logic [31:0] base_reg;
    logic [12:0] size_reg;
    logic [7:0]  fill_reg;
    line_t       line;
    logic [9:0]  ndigits;
    logic [3:0]  hi_nib;
    logic [7:0]  csum;
    logic [7:0]  rec_len;
    logic [15:0] rec_addr;
    logic [7:0]  rec_type;
    logic [7:0]  rec_bytes [RECORD_DEPTH];
    logic [7:0]  image [IMAGE_DEPTH];
    logic [31:0] addr_base;
    logic [12:0] lo_off, hi_off;
    logic        wrote, eof_flag;

    res_t expected_replies [$];

    function automatic void wipe_image();
        for (int i = 0; i < IMAGE_DEPTH; i++) image[i] = fill_reg;
        addr_base = '0;
        lo_off = '0;
        hi_off = '0;
        wrote = 1'b0;
        eof_flag = 1'b0;
    endfunction

    function automatic void queue_reply(reply_kind_t k, status_t s, logic [7:0] d);
        res_t r;
        r.kind = k;
        r.status = s;
        r.read_data = d;
        r.eof_hit = eof_flag;
        r.any_data = wrote;
        r.low_mark = lo_off;
        r.high_mark = hi_off;
        expected_replies.push_back(r);
    endfunction

    function automatic status_t close_record();
        logic [32:0] absolute;
        logic [32:0] offset;
        logic [32:0] lim;
        if (csum != 8'd0) return ST_CHECKSUM;
        case (rec_type)
            REC_DATA:
            begin
                absolute = {1'b0, addr_base + {16'd0, rec_addr}};
                if (absolute < {1'b0, base_reg}) return ST_OVERFLOW;
                offset = absolute - {1'b0, base_reg};
                lim = {20'd0, (size_reg < IMAGE_LIMIT) ? size_reg : IMAGE_LIMIT};
                if (offset + {25'd0, rec_len} > lim) return ST_OVERFLOW;
                for (int i = 0; i < rec_len; i++) image[offset + i] = rec_bytes[i];
                if (!wrote) begin
                    lo_off = offset[12:0];
                    hi_off = offset[12:0] + {5'd0, rec_len};
                    wrote = 1'b1;
                end
                else begin
                    if (offset[12:0] < lo_off) lo_off = offset[12:0];
                    if (offset[12:0] + {5'd0, rec_len} > hi_off)
                        hi_off = offset[12:0] + {5'd0, rec_len};
                end
                return ST_OK;
            end
            REC_EOF:
            begin
                eof_flag = 1'b1;
                return ST_OK;
            end
            REC_ESA, REC_ELA:
            begin
                if (rec_len != 8'd2) return ST_FORMAT;
                if (rec_type == REC_ELA) addr_base = {rec_bytes[0], rec_bytes[1], 16'd0};
                else addr_base = {12'd0, rec_bytes[0], rec_bytes[1], 4'd0};
                return ST_OK;
            end
            REC_SSA, REC_SLA: return ST_OK;
            default: return ST_UNSUPPORTED;
        endcase
    endfunction

    function automatic int nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        int v;
        logic [7:0] b;
        logic [8:0] idx;
        if (line == LN_DISCARD) begin
            if (c == 8'h0A) line = LN_SKIP;
            return;
        end
        if (line != LN_DIGITS) begin
            if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
            if (c == ":") begin
                line = LN_DIGITS;
                ndigits = '0;
                csum = '0;
                return;
            end
            line = LN_DISCARD;
            queue_reply(RK_STATUS, ST_FORMAT, 8'd0);
            return;
        end
        v = nibble_of(c);
        if (v < 0) begin
            line = (c == 8'h0A) ? LN_SKIP : LN_DISCARD;
            queue_reply(RK_STATUS, ST_FORMAT, 8'd0);
            return;
        end
        if (!ndigits[0]) begin
            hi_nib = v[3:0];
            ndigits++;
            return;
        end
        b = {hi_nib, v[3:0]};
        idx = ndigits[9:1];
        ndigits++;
        csum += b;
        if (idx == 0) rec_len = b;
        else if (idx == 1) rec_addr[15:8] = b;
        else if (idx == 2) rec_addr[7:0] = b;
        else if (idx == 3) rec_type = b;
        else if (idx < 4 + rec_len) rec_bytes[idx - 4] = b;
        else begin
            line = LN_DISCARD;
            queue_reply(RK_STATUS, close_record(), 8'd0);
        end
    endfunction

    // watch the channels and compare result beats
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n) begin
            base_reg = '0;
            size_reg = SIZE_RESET;
            fill_reg = FILL_RESET;
            line = LN_SKIP;
            ndigits = '0;
            hi_nib = '0;
            csum = '0;
            rec_len = '0;
            rec_addr = '0;
            rec_type = '0;
            wipe_image();
            expected_replies.delete();
            fail_count = 0;
            replies_seen = 0;
            pending = 0;
        end
        else begin
            if (!empty && pop) begin
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat kind=%0d status=%0d",
                                 reply_kind, status);
                end
                else begin
                    want = expected_replies.pop_front();
                    if (reply_kind !== want.kind || status !== want.status ||
                        read_data !== want.read_data || eof_hit !== want.eof_hit ||
                        any_data !== want.any_data || low_mark !== want.low_mark ||
                        high_mark !== want.high_mark) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch exp k%0d s%0d d%h e%b a%b lo%0d hi%0d got k%0d s%0d d%h e%b a%b lo%0d hi%0d",
                                     want.kind, want.status, want.read_data, want.eof_hit,
                                     want.any_data, want.low_mark, want.high_mark,
                                     reply_kind, status, read_data, eof_hit, any_data,
                                     low_mark, high_mark);
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_BASE) base_reg = cfg_data;
                else if (cfg_index == CFG_SIZE) size_reg = cfg_data[12:0];
                else if (cfg_index == CFG_FILL) fill_reg = cfg_data[7:0];
            end
            if (push && !full) begin
                if (req_type == REQ_CHAR) parse_char(char_code);
                else if (req_type == REQ_READ) queue_reply(RK_READ, ST_OK, image[read_index]);
                else if (req_type == REQ_CLEAR) begin
                    wipe_image();
                    queue_reply(RK_CLEAR, ST_OK, 8'd0);
                end
            end
            pending = expected_replies.size();
        end
    end

    // leftover expectations are counted by the top after draining
endmodule

`default_nettype wire

// ===== bench/intel_hex_record_loader_tb.sv =====
// testbench top for the hex record loader: stimulus, back-pressure and verdict
`default_nettype none

module intel_hex_record_loader_tb;
    import hexl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // request code with no meaning and a record type outside the known set
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [7:0] REC_BAD  = 8'h06;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [1:0]  req_type = REQ_CHAR;
    logic [7:0]  char_code = '0;
    logic [11:0] read_index = '0;
    logic        pop = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_BASE;
    logic [31:0] cfg_data = '0;
    logic        full, empty, eof_hit, any_data;
    logic [1:0]  reply_kind;
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic [12:0] low_mark, high_mark;
    int          fail_count, pending, replies_seen;
    int          beats_sent = 0;
    int          hold_cycles = 0;
    logic        drain_fast = 1'b0;
    logic [7:0]  line_buf [$];

    always #5 clk = ~clk;

    intel_hex_record_loader uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req_type(req_type),
        .char_code(char_code), .read_index(read_index), .empty(empty), .pop(pop),
        .reply_kind(reply_kind), .status(status), .read_data(read_data),
        .eof_hit(eof_hit), .any_data(any_data), .low_mark(low_mark),
        .high_mark(high_mark), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    intel_hex_record_loader_checker chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req_type(req_type),
        .char_code(char_code), .read_index(read_index), .empty(empty), .pop(pop),
        .reply_kind(reply_kind), .status(status), .read_data(read_data),
        .eof_hit(eof_hit), .any_data(any_data), .low_mark(low_mark),
        .high_mark(high_mark), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .replies_seen(replies_seen)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, plus one long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else if (drain_fast) pop <= 1'b1;
        else pop <= ($urandom_range(0, 3) != 0);
    end

    // push stays high after the beat is taken until the next gap or settle
    task automatic send_beat(input logic [1:0] rt, input logic [7:0] c, input logic [11:0] ri);
        int g;
        g = gap_len();
        repeat (g)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req_type <= rt;
        char_code <= c;
        read_index <= ri;
        @(posedge clk);
        while (full) @(posedge clk);
        beats_sent++;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 10) return 8'("0" + n);
        return 8'((upper ? "A" : "a") + n - 10);
    endfunction

    // build one record line into line_buf
    task automatic make_record(input logic [7:0] len, input logic [15:0] addr,
                               input logic [7:0] kind, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        bit up;
        up = 1'($urandom_range(0, 1));
        sum = len + addr[15:8] + addr[7:0] + kind;
        if ($urandom_range(0, 3) == 0) line_buf.push_back(8'h20);
        line_buf.push_back(":");
        line_buf.push_back(hex_char(len[7:4], up));
        line_buf.push_back(hex_char(len[3:0], up));
        line_buf.push_back(hex_char(addr[15:12], up));
        line_buf.push_back(hex_char(addr[11:8], up));
        line_buf.push_back(hex_char(addr[7:4], up));
        line_buf.push_back(hex_char(addr[3:0], up));
        line_buf.push_back(hex_char(kind[7:4], up));
        line_buf.push_back(hex_char(kind[3:0], up));
        for (int i = 0; i < len; i++) begin
            b = (kind == REC_ELA || kind == REC_ESA) ? 8'($urandom_range(0, 1)) : 8'($urandom);
            sum += b;
            line_buf.push_back(hex_char(b[7:4], up));
            line_buf.push_back(hex_char(b[3:0], up));
        end
        sum = -sum;
        if (bad_sum) sum ^= 8'h01 << $urandom_range(0, 7);
        line_buf.push_back(hex_char(sum[7:4], up));
        line_buf.push_back(hex_char(sum[3:0], up));
        if ($urandom_range(0, 2) == 0) line_buf.push_back(8'h0D);
        line_buf.push_back(8'h0A);
    endtask

    task automatic flush_line();
        while (line_buf.size() > 0) send_beat(REQ_CHAR, line_buf.pop_front(), '0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop offering, wait for every reply, then let a commit or clear settle
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending > 0) @(posedge clk);
        repeat (4400) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                make_record($urandom_range(0, 99) < 90 ? 8'($urandom_range(0, 16))
                                                       : 8'($urandom_range(17, 255)),
                            16'($urandom_range(0, 4200)), REC_DATA, $urandom_range(0, 9) == 0);
            else if (pick < 65)
                make_record(8'd2, 16'($urandom), ($urandom_range(0, 1) ? REC_ELA : REC_ESA),
                            1'b0);
            else if (pick < 70)
                make_record(8'($urandom_range(0, 3)), 16'($urandom), 8'($urandom_range(1, 7)),
                            1'b0);
            else if (pick < 73)
                make_record(8'($urandom_range(0, 2)), 16'($urandom), 8'($urandom), 1'b0);
            else if (pick < 88) begin
                send_beat(REQ_READ, 8'($urandom), 12'($urandom));
                continue;
            end
            else if (pick < 90) begin
                send_beat(REQ_CLEAR, 8'($urandom), 12'($urandom));
                continue;
            end
            else if (pick < 93) begin
                send_beat(REQ_NONE, 8'($urandom), 12'($urandom));
                continue;
            end
            else begin
                // noise and truncated lines
                repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom));
                if ($urandom_range(0, 1)) line_buf.push_back(":");
                line_buf.push_back(8'h0A);
            end
            flush_line();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: data, eof, extended, types, bad sum, bad digit, bad start
        make_record(8'd4, 16'h0010, REC_DATA, 1'b0);
        make_record(8'd0, 16'h0000, REC_DATA, 1'b0);
        make_record(8'd2, 16'h0000, REC_ELA, 1'b0);
        make_record(8'd2, 16'h0000, REC_ESA, 1'b0);
        make_record(8'd1, 16'h0000, REC_ESA, 1'b0);
        make_record(8'd4, 16'h0000, REC_SSA, 1'b0);
        make_record(8'd4, 16'h0000, REC_SLA, 1'b0);
        make_record(8'd0, 16'h0000, REC_BAD, 1'b0);
        make_record(8'd1, 16'hFFFF, REC_DATA, 1'b0);
        make_record(8'd1, 16'h0FFF, REC_DATA, 1'b0);
        make_record(8'd2, 16'h0020, REC_DATA, 1'b1);
        make_record(8'd0, 16'h0000, REC_EOF, 1'b0);
        line_buf.push_back("x");
        line_buf.push_back(8'h0A);
        line_buf.push_back(":");
        line_buf.push_back("1");
        line_buf.push_back("g");
        line_buf.push_back(8'h0A);
        line_buf.push_back(":");
        line_buf.push_back(8'h0A);
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h0A);
        flush_line();
        send_beat(REQ_READ, 8'd0, 12'h010);
        send_beat(REQ_READ, 8'd0, 12'hFFF);
        send_beat(REQ_NONE, 8'd0, 12'd0);
        send_beat(REQ_CLEAR, 8'd0, 12'd0);
        settle();

        // back-pressure: long hold-off while reads keep coming
        hold_cycles <= 300;
        repeat (20) send_beat(REQ_READ, 8'd0, 12'($urandom));
        settle();

        // configuration sweeps, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:
                begin
                    write_reg(CFG_BASE, 32'h0000_0100);
                    write_reg(CFG_SIZE, 32'd0);
                    write_reg(CFG_FILL, 32'h0000_0000);
                end
                1:
                begin
                    write_reg(CFG_BASE, 32'hFFFF_FFFF);
                    write_reg(CFG_SIZE, 32'h0000_1FFF);
                    write_reg(CFG_FILL, 32'h0000_00A5);
                end
                2:
                begin
                    write_reg(CFG_BASE, 32'h0001_0000);
                    write_reg(CFG_SIZE, 32'd64);
                    write_reg(CFG_FILL, 32'h0000_005A);
                end
                default:
                begin
                    write_reg(CFG_BASE, 32'd0);
                    write_reg(CFG_SIZE, 32'd4096);
                    write_reg(CFG_FILL, 32'h0000_00FF);
                end
            endcase
            send_beat(REQ_CLEAR, 8'd0, 12'd0);
            random_phase(ph == 3 ? 8 : 3);
            settle();
        end

        drain_fast <= 1'b1;
        settle();
        $display("covered %0d request beats and %0d result beats over four register settings",
                 beats_sent, replies_seen);
        $display("records with good and bad sums, extended bases, reads, clears and noise lines");
        if (fail_count == 0 && pending == 0)
            $display("intel_hex_record_loader verification clean");
        else
            $display("intel_hex_record_loader verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("intel_hex_record_loader verification failed");
        $finish;
    end
endmodule

`default_nettype wire
